@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file of the blink-code sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain concurrent assertion, disabled while reset is asserted.
`define RBCS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("rbcs assertion failed");

// Same-cycle implication, disabled while reset is asserted.
`define RBCS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("rbcs implication failed");

`endif

@@ hdl/rbcs_pkg.sv @@
// Shared types, constants and helper functions of the blink-code sequencer.
`default_nettype none

package rbcs_pkg;

  // Field and port widths.
  localparam int unsigned NUM_CH     = 3;
  localparam int unsigned LEVEL_W    = 6;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned COUNT_W    = 6;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Default saturation limit of a blink count magnitude.
  localparam int unsigned MAX_COUNT_DEF = 25;

  // Brightness limits and fixed colour parts.
  localparam logic [LEVEL_W-1:0] LEVEL_TOP        = 6'd32;
  localparam logic [LEVEL_W-1:0] YELLOW_GREEN_OFF = 6'd3;

  // Register reset values.
  localparam logic [PERIOD_W-1:0] PERIOD_RST     = 16'd250;
  localparam logic [LEVEL_W-1:0]  RED_ON_RST     = 6'd10;
  localparam logic [LEVEL_W-1:0]  GREEN_ON_RST   = 6'd3;
  localparam logic [LEVEL_W-1:0]  DIM_RST        = 6'd3;
  localparam logic [LEVEL_W-1:0]  YELLOW_RED_RST = 6'd15;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ABORT = 2'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RED_ON     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_ON   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIM        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_YELLOW_RED = 3'd4;

  // Effective configuration, levels already limited to the top level.
  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [LEVEL_W-1:0]  red_on;
    logic [LEVEL_W-1:0]  green_on;
    logic [LEVEL_W-1:0]  dim;
    logic [LEVEL_W-1:0]  yellow_red;
  } cfg_t;

  // One colour of one indicator.
  typedef struct packed {
    logic [LEVEL_W-1:0] r;
    logic [LEVEL_W-1:0] g;
    logic [LEVEL_W-1:0] b;
  } rgb_t;

  // One input transaction.
  typedef struct packed {
    logic [CMD_W-1:0]                command;
    logic [NUM_CH-1:0][COUNT_W-1:0]  count;
    logic [NUM_CH-1:0]               voted_in;
    logic [NUM_CH-1:0]               ok;
  } item_t;

  // Limits a written level to the top brightness.
  function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] v);
    return (v > LEVEL_TOP) ? LEVEL_TOP : v;
  endfunction

  // Background colour of the off phase.
  function automatic rgb_t off_colour(input logic ok, input logic vin, input cfg_t cfg);
    rgb_t c;
    c = '0;
    if (!ok) begin
      c.r = cfg.dim;
    end else if (!vin) begin
      c.r = cfg.yellow_red;
      c.g = YELLOW_GREEN_OFF;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hdl/rbcs_cfg_regs.sv @@
// Configuration registers of the blink-code sequencer.
`default_nettype none

module rbcs_cfg_regs import rbcs_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode a write; a zero period acts as one and levels saturate at the top.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PERIOD: begin
          cfg_d.period = (cfg_data_i[PERIOD_W-1:0] == '0) ? PERIOD_W'(1)
                                                          : cfg_data_i[PERIOD_W-1:0];
        end
        REG_RED_ON:     cfg_d.red_on     = clamp_level(cfg_data_i[LEVEL_W-1:0]);
        REG_GREEN_ON:   cfg_d.green_on   = clamp_level(cfg_data_i[LEVEL_W-1:0]);
        REG_DIM:        cfg_d.dim        = clamp_level(cfg_data_i[LEVEL_W-1:0]);
        REG_YELLOW_RED: cfg_d.yellow_red = clamp_level(cfg_data_i[LEVEL_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period     <= PERIOD_RST;
      cfg_q.red_on     <= RED_ON_RST;
      cfg_q.green_on   <= GREEN_ON_RST;
      cfg_q.dim        <= DIM_RST;
      cfg_q.yellow_red <= YELLOW_RED_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ hdl/rbcs_in_reg.sv @@
// Input register stage that holds one accepted transaction until it is processed.
`default_nettype none

module rbcs_in_reg import rbcs_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  wire item_t in_item_i,
  output logic       in_stall_o,
  input  wire logic  take_i,
  output logic       s1_valid_o,
  output item_t      s1_item_o
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  load;

  // The stage is free when empty or when its content moves on this cycle.
  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (load) begin
      valid_d = 1'b1;
      item_d  = in_item_i;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign s1_valid_o = valid_q;
  assign s1_item_o  = item_q;

endmodule

`default_nettype wire

@@ hdl/rbcs_core.sv @@
// Sequencer state, colour selection and result register of the blink-code sequencer.
`default_nettype none

module rbcs_core import rbcs_pkg::*; #(
  parameter int unsigned MaxCount = MAX_COUNT_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire cfg_t         cfg_i,
  input  wire logic         s1_valid_i,
  input  wire item_t        s1_item_i,
  input  wire logic         out_stall_i,
  output logic              take_o,
  output logic              out_valid_o,
  output rgb_t [NUM_CH-1:0] colour_o,
  output logic              busy_o
);

  localparam int unsigned CntW = $clog2(MaxCount + 1);

  // Colour of one channel during an on phase.
  function automatic rgb_t on_colour(input logic [CntW-1:0] mag, input logic neg,
                                     input logic ok, input logic vin,
                                     input logic [CntW-1:0] idx, input rgb_t prev,
                                     input cfg_t cfg);
    rgb_t c;
    c = prev;
    if (mag != '0) begin
      c = '0;
      if (idx < mag) begin
        if (!neg && ok) begin
          c.g = cfg.green_on;
        end else begin
          c.r = cfg.red_on;
        end
      end else if (!ok) begin
        c.r = cfg.dim;
      end else if (!vin) begin
        c.r = cfg.dim;
        c.g = cfg.dim;
      end
    end
    return c;
  endfunction

  // State registers.
  logic [CntW-1:0]     mag_q [NUM_CH];
  logic [CntW-1:0]     mag_d [NUM_CH];
  logic [NUM_CH-1:0]   neg_q, neg_d;
  logic [NUM_CH-1:0]   vin_q, vin_d;
  logic [NUM_CH-1:0]   ok_q, ok_d;
  logic [CntW-1:0]     run_len_q, run_len_d;
  logic [CntW-1:0]     idx_q, idx_d;
  logic                off_q, off_d;
  logic [PERIOD_W-1:0] timer_q, timer_d;
  logic                running_q, running_d;
  rgb_t [NUM_CH-1:0]   colour_q, colour_d;
  logic                out_valid_q, out_valid_d;

  // Start operands after saturation.
  logic [CntW-1:0]     new_mag [NUM_CH];
  logic [NUM_CH-1:0]   new_neg;
  logic [CntW-1:0]     new_run_len;

  logic [PERIOD_W:0]   timer_sum;
  logic                period_hit;
  logic [CntW-1:0]     idx_inc;

  // A transaction is processed when the result register is free or drains now.
  assign take_o = s1_valid_i && (!out_valid_q || !out_stall_i);

  // Saturate the signed counts to sign and magnitude.
  always_comb begin
    logic [COUNT_W:0] ext;
    logic [COUNT_W:0] mag_ext;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      ext     = {s1_item_i.count[ch][COUNT_W-1], s1_item_i.count[ch]};
      mag_ext = s1_item_i.count[ch][COUNT_W-1] ? ((COUNT_W+1)'(0) - ext) : ext;
      if (mag_ext > (COUNT_W+1)'(MaxCount)) begin
        mag_ext = (COUNT_W+1)'(MaxCount);
      end
      new_mag[ch] = mag_ext[CntW-1:0];
      new_neg[ch] = s1_item_i.count[ch][COUNT_W-1];
    end
  end

  // Run length is the largest magnitude among the channels that are ok.
  always_comb begin
    new_run_len = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (s1_item_i.ok[ch] && (new_mag[ch] > new_run_len)) begin
        new_run_len = new_mag[ch];
      end
    end
  end

  assign timer_sum  = {1'b0, timer_q} + (PERIOD_W+1)'(1);
  assign period_hit = timer_sum >= {1'b0, cfg_i.period};
  assign idx_inc    = idx_q + CntW'(1);

  // Next state for one processed transaction.
  always_comb begin
    mag_d     = mag_q;
    neg_d     = neg_q;
    vin_d     = vin_q;
    ok_d      = ok_q;
    run_len_d = run_len_q;
    idx_d     = idx_q;
    off_d     = off_q;
    timer_d   = timer_q;
    running_d = running_q;
    colour_d  = colour_q;
    if (take_o) begin
      case (s1_item_i.command)
        CMD_START: begin
          mag_d     = new_mag;
          neg_d     = new_neg;
          vin_d     = s1_item_i.voted_in;
          ok_d      = s1_item_i.ok;
          run_len_d = new_run_len;
          idx_d     = '0;
          off_d     = 1'b0;
          timer_d   = '0;
          running_d = (new_run_len != '0);
          if (new_run_len != '0) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
              colour_d[ch] = on_colour(new_mag[ch], new_neg[ch], s1_item_i.ok[ch],
                                       s1_item_i.voted_in[ch], '0, colour_q[ch], cfg_i);
            end
          end
        end
        CMD_ABORT: begin
          running_d = 1'b0;
        end
        CMD_TICK: begin
          if (running_q) begin
            timer_d = timer_sum[PERIOD_W-1:0];
            if (period_hit) begin
              timer_d = '0;
              if (!off_q) begin
                off_d = 1'b1;
                for (int ch = 0; ch < NUM_CH; ch++) begin
                  colour_d[ch] = off_colour(ok_q[ch], vin_q[ch], cfg_i);
                end
              end else begin
                off_d = 1'b0;
                idx_d = idx_inc;
                if (idx_inc >= run_len_q) begin
                  running_d = 1'b0;
                end else begin
                  for (int ch = 0; ch < NUM_CH; ch++) begin
                    colour_d[ch] = on_colour(mag_q[ch], neg_q[ch], ok_q[ch], vin_q[ch],
                                             idx_inc, colour_q[ch], cfg_i);
                  end
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (take_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        mag_q[ch] <= '0;
      end
      neg_q       <= '0;
      vin_q       <= '0;
      ok_q        <= '0;
      run_len_q   <= '0;
      idx_q       <= '0;
      off_q       <= 1'b0;
      timer_q     <= '0;
      running_q   <= 1'b0;
      colour_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mag_q       <= mag_d;
      neg_q       <= neg_d;
      vin_q       <= vin_d;
      ok_q        <= ok_d;
      run_len_q   <= run_len_d;
      idx_q       <= idx_d;
      off_q       <= off_d;
      timer_q     <= timer_d;
      running_q   <= running_d;
      colour_q    <= colour_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The colour and busy state change only when a result is loaded, so they are the payload.
  assign out_valid_o = out_valid_q;
  assign colour_o    = colour_q;
  assign busy_o      = running_q;

endmodule

`default_nettype wire

@@ hdl/rgb_blink_code_sequencer_unit.sv @@
// Top level of the RGB blink-code sequencer for three indicators.
//
// Input channel: in_valid_i / in_stall_o carry one transaction per unstalled cycle with a
// command (tick, start code, abort), three signed blink counts and the voted-in and ok masks.
// Output channel: out_valid_o / out_stall_i carry one result per input transaction:
// the nine brightness levels and the busy flag after that transaction.
// Configuration: cfg_we_i writes cfg_data_i into the register at cfg_idx_i
// (period, red level, green level, dim level, yellow red level) at a clock edge.
// A transaction accepted into the input register is processed by the core stage once
// the result register is free or drains; its result is then offered from the result
// register. Throughput is one transaction per cycle while out_stall_i is low, and the
// core stage updates the sequencer state. A stalled result holds; the input register can
// still take one more transaction, after which in_stall_o rises until the result is taken.
// Reset clears the sequencer (LEDs off, not busy), both stages and loads the default
// register values; no clearing pass is needed, so the block is ready at once.
`default_nettype none

module rgb_blink_code_sequencer_unit import rbcs_pkg::*; #(
  parameter int unsigned MaxCount = MAX_COUNT_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input channel
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [CMD_W-1:0]      command_i,
  input  wire logic signed [COUNT_W-1:0] count_a_i,
  input  wire logic signed [COUNT_W-1:0] count_b_i,
  input  wire logic signed [COUNT_W-1:0] count_c_i,
  input  wire logic [NUM_CH-1:0]     voted_in_mask_i,
  input  wire logic [NUM_CH-1:0]     ok_mask_i,
  // Output channel
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [LEVEL_W-1:0]         a_red_o,
  output logic [LEVEL_W-1:0]         a_green_o,
  output logic [LEVEL_W-1:0]         a_blue_o,
  output logic [LEVEL_W-1:0]         b_red_o,
  output logic [LEVEL_W-1:0]         b_green_o,
  output logic [LEVEL_W-1:0]         b_blue_o,
  output logic [LEVEL_W-1:0]         c_red_o,
  output logic [LEVEL_W-1:0]         c_green_o,
  output logic [LEVEL_W-1:0]         c_blue_o,
  output logic                       busy_res_o
);

  cfg_t              cfg;
  item_t             in_item;
  item_t             s1_item;
  logic              s1_valid;
  logic              take;
  rgb_t [NUM_CH-1:0] colour;

  // Gather the input fields into one transaction.
  always_comb begin
    in_item.command  = command_i;
    in_item.count[0] = count_a_i;
    in_item.count[1] = count_b_i;
    in_item.count[2] = count_c_i;
    in_item.voted_in = voted_in_mask_i;
    in_item.ok       = ok_mask_i;
  end

  rbcs_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  rbcs_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item),
    .in_stall_o (in_stall_o),
    .take_i     (take),
    .s1_valid_o (s1_valid),
    .s1_item_o  (s1_item)
  );

  rbcs_core #(
    .MaxCount (MaxCount)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .s1_valid_i  (s1_valid),
    .s1_item_i   (s1_item),
    .out_stall_i (out_stall_i),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .colour_o    (colour),
    .busy_o      (busy_res_o)
  );

  // Spread the colour state over the output fields.
  assign a_red_o   = colour[0].r;
  assign a_green_o = colour[0].g;
  assign a_blue_o  = colour[0].b;
  assign b_red_o   = colour[1].r;
  assign b_green_o = colour[1].g;
  assign b_blue_o  = colour[1].b;
  assign c_red_o   = colour[2].r;
  assign c_green_o = colour[2].g;
  assign c_blue_o  = colour[2].b;

endmodule

`default_nettype wire

@@ hdl/rbcs_checker.sv @@
// Port-level assertion checker of the blink-code sequencer and its bind statement.
`default_nettype none
`include "assert_macros.svh"

module rbcs_checker import rbcs_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_i,
  input wire logic               out_valid_i,
  input wire logic               out_stall_i,
  input wire logic [LEVEL_W-1:0] a_red_i,
  input wire logic               busy_i
);

  // A stalled result stays offered and keeps its payload.
  `RBCS_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_i && out_stall_i) |=> out_valid_i)
  `RBCS_ASSERT(a_out_stable, clk_i, rst_ni, (out_valid_i && out_stall_i) |=> ($stable(busy_i) && $stable(a_red_i)))

  // An accepted transaction gives a result once the output side is free.
  `RBCS_ASSERT(a_in_to_out, clk_i, rst_ni, ((in_valid_i && !in_stall_i) ##1 (!out_valid_i || !out_stall_i)) |=> out_valid_i)

  // The input side stalls only while a result is held back.
  `RBCS_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_i, out_valid_i && out_stall_i)

  // Colours and busy change only together with a new result.
  `RBCS_ASSERT_IMP(a_change_valid, clk_i, rst_ni, !$stable(busy_i) || !$stable(a_red_i), out_valid_i)

endmodule

bind rgb_blink_code_sequencer_unit rbcs_checker u_rbcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .a_red_i     (a_red_o),
  .busy_i      (busy_res_o)
);

`default_nettype wire
